/* sv/lexer_with_symbol_table_core_assert.svh */
`ifndef LEXER_WITH_SYMBOL_TABLE_CORE_ASSERT_SVH
`define LEXER_WITH_SYMBOL_TABLE_CORE_ASSERT_SVH

// check a condition on every clock edge out of reset
`define LWST_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// check a consequence in the same cycle as its cause
`define LWST_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* sv/lwst_pkg.sv */
package lwst_pkg;

  localparam int NAME_BUFFER_BYTES_DEF = 128;
  localparam int LEXEME_BYTES_DEF      = 1024;
  localparam int SYMBOL_ENTRIES_DEF    = 128;

  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 3;
  localparam int VALUE_W = 31;
  localparam int LINE_W  = 24;
  localparam int ERR_W   = 2;

  localparam logic [VALUE_W-1:0] NUM_MAX  = '1;
  localparam logic [LINE_W-1:0]  LINE_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd0;
  localparam logic [KIND_W-1:0] KIND_IDENT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DIV    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MOD    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SINGLE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DONE   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd6;

  localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NAME_LONG  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_TABLE_FULL = 2'd2;
  localparam logic [ERR_W-1:0] ERR_STORE_FULL = 2'd3;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [LINE_W-1:0]  line;
    logic [ERR_W-1:0]   err;
    logic               last;
  } res_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic scan_emits(input logic [CHAR_W-1:0] c, input logic eoi);
    return eoi || !(c == CH_SPACE || c == CH_TAB || c == CH_NL || is_digit(c) || is_alpha(c));
  endfunction

  function automatic logic [CHAR_W-1:0] keyword_byte(input logic [2:0] idx);
    logic [CHAR_W-1:0] b;
    case (idx)
      3'd0:    b = 8'h64;
      3'd1:    b = 8'h69;
      3'd2:    b = 8'h76;
      3'd4:    b = 8'h6d;
      3'd5:    b = 8'h6f;
      3'd6:    b = 8'h64;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* sv/lwst_in_if.sv */
interface lwst_in_if;
  logic                      valid;
  logic                      ready;
  logic [lwst_pkg::CHAR_W-1:0] char_code;
  logic                      end_of_input;

  modport source (output valid, char_code, end_of_input, input ready);
  modport sink (input valid, char_code, end_of_input, output ready);
endinterface

/* sv/lwst_out_if.sv */
interface lwst_out_if;
  logic                         valid;
  logic                         ready;
  logic [lwst_pkg::KIND_W-1:0]  token_kind;
  logic [lwst_pkg::VALUE_W-1:0] token_value;
  logic [lwst_pkg::LINE_W-1:0]  line_number;
  logic [lwst_pkg::ERR_W-1:0]   error_code;
  logic                         last_result;

  modport source (output valid, token_kind, token_value, line_number, error_code,
                  last_result, input ready);
  modport sink (input valid, token_kind, token_value, line_number, error_code,
                last_result, output ready);
endinterface

/* sv/lwst_ram.sv */
module lwst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/lexer_with_symbol_table_core.sv */
// Lexer with symbol table. Takes one character request at a time and is ready again once
// the request is handled: a number or name character passes the dispatch state; a
// skipped or single-character request dispatch and scan. A name end walks the symbol
// table newest entry first, checking each length and comparing bytes on a match; an
// insert copies the name, then writes its terminator and start entry. Results leave
// through a one-deep output register, so the next request is taken while a result waits.
// The keywords div and mod are preloaded, no clearing pass runs after reset. An error
// result halts the block; later requests are taken and dropped until reset.
module lexer_with_symbol_table_core #(
  parameter int NAME_BUFFER_BYTES = lwst_pkg::NAME_BUFFER_BYTES_DEF,
  parameter int LEXEME_BYTES      = lwst_pkg::LEXEME_BYTES_DEF,
  parameter int SYMBOL_ENTRIES    = lwst_pkg::SYMBOL_ENTRIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lwst_in_if.sink    in_req_i,
  lwst_out_if.source out_req_o
);
  import lwst_pkg::*;
  `include "lexer_with_symbol_table_core_assert.svh"

  localparam int NAW  = $clog2(NAME_BUFFER_BYTES);
  localparam int LAW  = $clog2(LEXEME_BYTES);
  localparam int SAW  = $clog2(SYMBOL_ENTRIES);
  localparam int SUMW = ((LAW > NAW) ? LAW : NAW) + 2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_SCAN, ST_LK_RDS, ST_LK_WTS, ST_LK_RDB, ST_LK_CMP,
    ST_INS_CHK, ST_INS_RD, ST_INS_WR, ST_INS_END, ST_EMIT
  } st_e;

  typedef enum logic [1:0] {MODE_IDLE, MODE_NUM, MODE_NAME} mode_e;

  st_e                st_q, st_d;
  mode_e              mode_q, mode_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic [NAW-1:0]     len_q, len_d;
  logic [LINE_W-1:0]  line_q, line_d;
  logic [SAW-1:0]     count_q, count_d;
  logic [LAW-1:0]     fill_q, fill_d;
  logic               halted_q, halted_d;
  logic [CHAR_W-1:0]  c_q, c_d;
  logic               eoi_q, eoi_d;
  logic [SAW-1:0]     p_q, p_d;
  logic [LAW-1:0]     next_q, next_d;
  logic [LAW-1:0]     s_q, s_d;
  logic [NAW-1:0]     k_q, k_d;
  logic [LAW-1:0]     lex_addr_q, lex_addr_d;
  res_t               res_q, res_d;
  logic               ovalid_q, ovalid_d;

  logic              nb_we, lx_we, es_we;
  logic [NAW-1:0]    nb_addr;
  logic [LAW-1:0]    lx_addr;
  logic [SAW-1:0]    es_addr;
  logic [CHAR_W-1:0] nb_wdata, nb_rdata, lx_wdata, lx_rdata;
  logic [LAW-1:0]    es_wdata, es_rdata;

  logic              can_push, push, emits;
  res_t              push_res;
  logic [34:0]       acc_ext;
  logic [LAW-1:0]    s_cur, e_cur;
  logic [CHAR_W-1:0] lex_byte;

  lwst_ram #(.WIDTH(CHAR_W), .DEPTH(NAME_BUFFER_BYTES)) u_name_ram (
    .clk_i(clk_i), .we_i(nb_we), .addr_i(nb_addr), .wdata_i(nb_wdata), .rdata_o(nb_rdata)
  );

  lwst_ram #(.WIDTH(CHAR_W), .DEPTH(LEXEME_BYTES)) u_lexeme_ram (
    .clk_i(clk_i), .we_i(lx_we), .addr_i(lx_addr), .wdata_i(lx_wdata), .rdata_o(lx_rdata)
  );

  lwst_ram #(.WIDTH(LAW), .DEPTH(SYMBOL_ENTRIES)) u_start_ram (
    .clk_i(clk_i), .we_i(es_we), .addr_i(es_addr), .wdata_i(es_wdata), .rdata_o(es_rdata)
  );

  assign can_push = !ovalid_q || out_req_o.ready;
  assign emits    = scan_emits(c_q, eoi_q);
  assign acc_ext  = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + 35'(c_q - CH_ZERO);
  assign s_cur    = (p_q == SAW'(1)) ? LAW'(0) : (p_q == SAW'(2)) ? LAW'(4) : es_rdata;
  assign e_cur    = next_q - LAW'(1);
  assign lex_byte = (lex_addr_q < LAW'(8)) ? keyword_byte(lex_addr_q[2:0]) : lx_rdata;

  always_comb begin
    st_d       = st_q;
    mode_d     = mode_q;
    acc_d      = acc_q;
    len_d      = len_q;
    line_d     = line_q;
    count_d    = count_q;
    fill_d     = fill_q;
    halted_d   = halted_q;
    c_d        = c_q;
    eoi_d      = eoi_q;
    p_d        = p_q;
    next_d     = next_q;
    s_d        = s_q;
    k_d        = k_q;
    lex_addr_d = lex_addr_q;
    push       = 1'b0;
    push_res   = '{kind: KIND_ERROR, value: '0, line: line_q, err: ERR_NONE, last: 1'b1};
    nb_we      = 1'b0;
    nb_addr    = k_q;
    nb_wdata   = c_q;
    lx_we      = 1'b0;
    lx_addr    = lex_addr_q;
    lx_wdata   = nb_rdata;
    es_we      = 1'b0;
    es_addr    = p_q;
    es_wdata   = LAW'(SUMW'(fill_q) + SUMW'(1));
    in_req_i.ready = (st_q == ST_IDLE);

    unique case (st_q)
      ST_IDLE: begin
        if (in_req_i.valid) begin
          c_d   = in_req_i.char_code;
          eoi_d = in_req_i.end_of_input;
          if (!halted_q) begin
            st_d = ST_DISPATCH;
          end
        end
      end
      ST_DISPATCH: begin
        unique case (mode_q)
          MODE_NUM: begin
            if (!eoi_q && is_digit(c_q)) begin
              acc_d = (acc_ext > 35'(NUM_MAX)) ? NUM_MAX : acc_ext[VALUE_W-1:0];
              st_d  = ST_IDLE;
            end else if (can_push) begin
              push     = 1'b1;
              push_res = '{kind: KIND_NUMBER, value: acc_q, line: line_q, err: ERR_NONE,
                           last: !emits};
              mode_d   = MODE_IDLE;
              st_d     = ST_SCAN;
            end
          end
          MODE_NAME: begin
            if (!eoi_q && (is_digit(c_q) || is_alpha(c_q))) begin
              if ((NAW+1)'(len_q) + (NAW+1)'(1) >= (NAW+1)'(NAME_BUFFER_BYTES)) begin
                if (can_push) begin
                  push     = 1'b1;
                  push_res = '{kind: KIND_ERROR, value: '0, line: line_q,
                               err: ERR_NAME_LONG, last: 1'b1};
                  halted_d = 1'b1;
                  st_d     = ST_IDLE;
                end
              end else begin
                nb_we   = 1'b1;
                nb_addr = len_q;
                len_d   = len_q + NAW'(1);
                st_d    = ST_IDLE;
              end
            end else begin
              p_d    = count_q;
              next_d = LAW'(SUMW'(fill_q) + SUMW'(1));
              st_d   = ST_LK_RDS;
            end
          end
          default: begin
            st_d = ST_SCAN;
          end
        endcase
      end
      ST_SCAN: begin
        if (emits) begin
          if (can_push) begin
            push     = 1'b1;
            push_res = eoi_q
                ? '{kind: KIND_DONE, value: '0, line: line_q, err: ERR_NONE, last: 1'b1}
                : '{kind: KIND_SINGLE, value: VALUE_W'(c_q), line: line_q, err: ERR_NONE,
                    last: 1'b1};
            st_d     = ST_IDLE;
          end
        end else begin
          st_d = ST_IDLE;
          if (c_q == CH_NL) begin
            if (line_q != LINE_MAX) begin
              line_d = line_q + LINE_W'(1);
            end
          end else if (is_digit(c_q)) begin
            mode_d = MODE_NUM;
            acc_d  = VALUE_W'(c_q - CH_ZERO);
          end else if (is_alpha(c_q)) begin
            mode_d  = MODE_NAME;
            nb_we   = 1'b1;
            nb_addr = '0;
            len_d   = NAW'(1);
          end
        end
      end
      ST_LK_RDS: begin
        es_addr = p_q;
        st_d    = (p_q == '0) ? ST_INS_CHK : ST_LK_WTS;
      end
      ST_LK_WTS: begin
        s_d    = s_cur;
        next_d = s_cur;
        k_d    = '0;
        if (SUMW'(e_cur - s_cur) == SUMW'(len_q)) begin
          st_d = ST_LK_RDB;
        end else begin
          p_d  = p_q - SAW'(1);
          st_d = ST_LK_RDS;
        end
      end
      ST_LK_RDB: begin
        lx_addr    = LAW'(SUMW'(s_q) + SUMW'(k_q));
        lex_addr_d = lx_addr;
        nb_addr    = k_q;
        st_d       = ST_LK_CMP;
      end
      ST_LK_CMP: begin
        if (lex_byte == nb_rdata) begin
          if ((NAW+1)'(k_q) + (NAW+1)'(1) == (NAW+1)'(len_q)) begin
            st_d = ST_EMIT;
          end else begin
            k_d  = k_q + NAW'(1);
            st_d = ST_LK_RDB;
          end
        end else begin
          p_d  = p_q - SAW'(1);
          st_d = ST_LK_RDS;
        end
      end
      ST_INS_CHK: begin
        if ((SAW+1)'(count_q) + (SAW+1)'(1) >= (SAW+1)'(SYMBOL_ENTRIES)) begin
          if (can_push) begin
            push     = 1'b1;
            push_res = '{kind: KIND_ERROR, value: '0, line: line_q, err: ERR_TABLE_FULL,
                         last: 1'b1};
            halted_d = 1'b1;
            st_d     = ST_IDLE;
          end
        end else if (SUMW'(fill_q) + SUMW'(len_q) + SUMW'(1) >= SUMW'(LEXEME_BYTES)) begin
          if (can_push) begin
            push     = 1'b1;
            push_res = '{kind: KIND_ERROR, value: '0, line: line_q, err: ERR_STORE_FULL,
                         last: 1'b1};
            halted_d = 1'b1;
            st_d     = ST_IDLE;
          end
        end else begin
          k_d  = '0;
          st_d = ST_INS_RD;
        end
      end
      ST_INS_RD: begin
        nb_addr = k_q;
        st_d    = ST_INS_WR;
      end
      ST_INS_WR: begin
        lx_we    = 1'b1;
        lx_addr  = LAW'(SUMW'(fill_q) + SUMW'(1) + SUMW'(k_q));
        lx_wdata = nb_rdata;
        k_d      = k_q + NAW'(1);
        if ((NAW+1)'(k_q) + (NAW+1)'(1) == (NAW+1)'(len_q)) begin
          st_d = ST_INS_END;
        end else begin
          st_d = ST_INS_RD;
        end
      end
      ST_INS_END: begin
        lx_we    = 1'b1;
        lx_addr  = LAW'(SUMW'(fill_q) + SUMW'(1) + SUMW'(len_q));
        lx_wdata = '0;
        es_we    = 1'b1;
        es_addr  = count_q + SAW'(1);
        es_wdata = LAW'(SUMW'(fill_q) + SUMW'(1));
        count_d  = count_q + SAW'(1);
        fill_d   = LAW'(SUMW'(fill_q) + SUMW'(1) + SUMW'(len_q));
        p_d      = count_q + SAW'(1);
        st_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (can_push) begin
          push     = 1'b1;
          push_res = '{kind: (p_q == SAW'(1)) ? KIND_DIV
                             : (p_q == SAW'(2)) ? KIND_MOD : KIND_IDENT,
                       value: VALUE_W'(p_q), line: line_q, err: ERR_NONE, last: !emits};
          mode_d   = MODE_IDLE;
          st_d     = ST_SCAN;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    ovalid_d = push ? 1'b1 : (out_req_o.ready ? 1'b0 : ovalid_q);
    res_d    = push ? push_res : res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      mode_q   <= MODE_IDLE;
      acc_q    <= '0;
      len_q    <= '0;
      line_q   <= LINE_W'(1);
      count_q  <= SAW'(2);
      fill_q   <= LAW'(7);
      halted_q <= 1'b0;
      ovalid_q <= 1'b0;
      p_q      <= '0;
      k_q      <= '0;
    end else begin
      st_q     <= st_d;
      mode_q   <= mode_d;
      acc_q    <= acc_d;
      len_q    <= len_d;
      line_q   <= line_d;
      count_q  <= count_d;
      fill_q   <= fill_d;
      halted_q <= halted_d;
      ovalid_q <= ovalid_d;
      p_q      <= p_d;
      k_q      <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q        <= c_d;
    eoi_q      <= eoi_d;
    next_q     <= next_d;
    s_q        <= s_d;
    lex_addr_q <= lex_addr_d;
    res_q      <= res_d;
  end

  assign out_req_o.valid       = ovalid_q;
  assign out_req_o.token_kind  = res_q.kind;
  assign out_req_o.token_value = res_q.value;
  assign out_req_o.line_number = res_q.line;
  assign out_req_o.error_code  = res_q.err;
  assign out_req_o.last_result = res_q.last;

  `LWST_ASSERT_IMPLY(a_halt_silent, halted_q, !push, "result pushed while halted")
  `LWST_ASSERT_ALWAYS(a_count_room,
                      count_q >= SAW'(2) && (SAW+1)'(count_q) < (SAW+1)'(SYMBOL_ENTRIES),
                      "symbol count overrun")
  `LWST_ASSERT_IMPLY(a_walk_bound, st_q == ST_LK_WTS || st_q == ST_LK_CMP,
                     p_q != '0 && p_q <= count_q, "table walk out of range")
  `LWST_ASSERT_IMPLY(a_name_len, mode_q == MODE_NAME && !halted_q, len_q != '0,
                     "empty name in progress")

endmodule
